// ===== rtl/core/cppd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cppd_pkg
// Shared types and constants for the column post picture decoder core.
// ----------------------------------------------------------------------------
package cppd_pkg;

	localparam int ENTRY_AW    = 16;
	localparam int PIXEL_AW    = 16;
	localparam int PAL_AW      = 10;
	localparam int SIZE_W      = 17;
	localparam int PAL_BYTES   = 768;
	localparam int ENTRY_DEPTH = 65536;
	localparam int PIXEL_DEPTH = 65536;

	localparam logic [7:0] END_MARK    = 8'hFF;
	localparam logic [7:0] ALPHA_OPQ   = 8'hFF;
	localparam logic [SIZE_W-1:0] HDR_BYTES = SIZE_W'(8);

	typedef enum logic [1:0] {
		ACT_PAL_LOAD   = 2'd0,
		ACT_ENTRY_LOAD = 2'd1,
		ACT_DECODE     = 2'd2,
		ACT_READ       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_TABLE = 2'd1,
		STAT_TOO_BIG   = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RDPIX,
		S_HDR_RD,
		S_HDR_WT,
		S_HDR_MUL,
		S_HDR_CHK,
		S_CLR,
		S_TAB_RD,
		S_TAB_WT,
		S_POST,
		S_TOP_WT,
		S_LEN_WT,
		S_PIX_RD,
		S_PIX_WT,
		S_PAL_RD,
		S_PAL_WT,
		S_PIX_WR
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/column_post_picture_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// column_post_picture_decoder_core
// Column/post picture decoder: byte loads, decode walk, pixel reads.
// ----------------------------------------------------------------------------
// Decode: clears w*h pixel store entries, then walks each column, its posts and
//   their pixels; its pace is set by the single entry store read port and
//   the byte-wide palette store that is read three times per pixel.
// One item in flight; next is taken once its result is registered, bar a stall.
// Reset clears control state and the decoded size; stores are not cleared.

module column_post_picture_decoder_core
	import cppd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// palette_position, entry_offset, byte_value, entry_size, pixel_number
	input  wire logic [71:0] s_tdata,
	// action
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status, picture_width, picture_height, argb
	output logic [71:0]      m_tdata
);

	// input fields
	logic [PAL_AW-1:0]   palette_position;
	logic [ENTRY_AW-1:0] entry_offset;
	logic [7:0]          byte_value;
	logic [SIZE_W-1:0]   entry_size;
	logic [PIXEL_AW-1:0] pixel_number;
	action_t             action;

	assign palette_position = s_tdata[9:0];
	assign entry_offset     = s_tdata[25:10];
	assign byte_value       = s_tdata[33:26];
	assign entry_size       = s_tdata[50:34];
	assign pixel_number     = s_tdata[66:51];
	assign action           = action_t'(s_tuser);

	// memories
	logic [7:0]  pal_mem [PAL_BYTES];
	logic [7:0]  ent_mem [ENTRY_DEPTH];
	logic [24:0] pix_mem [PIXEL_DEPTH];

	logic                pal_we, ent_we, pix_we;
	logic [PAL_AW-1:0]   pal_raddr;
	logic [ENTRY_AW-1:0] ent_raddr;
	logic [PIXEL_AW-1:0] pix_waddr;
	logic [24:0]         pix_wdata;
	logic [7:0]          pal_rdata_q, ent_rdata_q;
	logic [24:0]         pix_rdata_q;

	// control and datapath registers
	state_t              state_q, state_d;
	logic                m_tvalid_q;
	logic [71:0]         m_tdata_q;
	logic [15:0]         dec_w_q, dec_h_q;
	logic [SIZE_W-1:0]   dec_area_q;
	logic [SIZE_W-1:0]   size_q;
	logic [31:0]         acc_q;
	logic [1:0]          cnt_q;
	logic [15:0]         w_q, h_q;
	logic [31:0]         area_q;
	logic [PIXEL_AW-1:0] clr_q;
	logic [15:0]         col_q;
	logic [31:0]         pos_q;
	logic [7:0]          top_q, len_q, y_q;
	logic [17:0]         start_q;
	logic [8:0]          row_q;
	logic [PIXEL_AW-1:0] rowbase_q;
	logic [PAL_AW-1:0]   pal_base_q;
	logic [23:0]         rgb_q;
	logic [PIXEL_AW-1:0] pnum_q;

	// combinational control
	logic              accept;
	logic [SIZE_W-1:0] size_sat;
	logic              tab_bad, col_last, clr_last, col_end;
	logic              fin, fin_dec;
	status_t           fin_status;
	logic [31:0]       fin_argb;
	logic [17:0]       start_d;

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign size_sat = (entry_size > SIZE_W'(ENTRY_DEPTH)) ? SIZE_W'(ENTRY_DEPTH) : entry_size;
	assign tab_bad  = ({1'b0, w_q, 2'b00} + 19'd8) > {2'b00, size_q};
	assign col_last = (col_q == w_q - 16'd1);
	assign clr_last = ({16'd0, clr_q} + 32'd1) == area_q;
	assign start_d  = pos_q[17:0] + 18'd3;

	// next state, memory controls and result
	always_comb begin
		state_d    = state_q;
		pal_we     = 1'b0;
		ent_we     = 1'b0;
		pix_we     = 1'b0;
		pal_raddr  = pal_base_q + PAL_AW'(cnt_q);
		ent_raddr  = '0;
		pix_waddr  = clr_q;
		pix_wdata  = '0;
		fin        = 1'b0;
		fin_dec    = 1'b0;
		fin_status = STAT_OK;
		fin_argb   = '0;
		col_end    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_PAL_LOAD: begin
							pal_we = (palette_position < PAL_AW'(PAL_BYTES));
							fin    = 1'b1;
						end
						ACT_ENTRY_LOAD: begin
							ent_we = 1'b1;
							fin    = 1'b1;
						end
						ACT_DECODE: begin
							if (size_sat < HDR_BYTES) begin
								fin        = 1'b1;
								fin_dec    = 1'b1;
								fin_status = STAT_BAD_TABLE;
							end else begin
								state_d = S_HDR_RD;
							end
						end
						default: state_d = S_RDPIX;
					endcase
				end
			end
			S_RDPIX: begin
				fin = 1'b1;
				if (({1'b0, pnum_q} < dec_area_q) && pix_rdata_q[24])
					fin_argb = {ALPHA_OPQ, pix_rdata_q[23:0]};
				state_d = S_IDLE;
			end
			S_HDR_RD: begin
				ent_raddr = ENTRY_AW'(cnt_q);
				state_d   = S_HDR_WT;
			end
			S_HDR_WT: state_d = (cnt_q == 2'd3) ? S_HDR_MUL : S_HDR_RD;
			S_HDR_MUL: state_d = S_HDR_CHK;
			S_HDR_CHK: begin
				if (tab_bad) begin
					fin = 1'b1; fin_dec = 1'b1; fin_status = STAT_BAD_TABLE;
					state_d = S_IDLE;
				end else if (area_q > 32'(PIXEL_DEPTH)) begin
					fin = 1'b1; fin_dec = 1'b1; fin_status = STAT_TOO_BIG;
					state_d = S_IDLE;
				end else if (w_q == 16'd0) begin
					fin = 1'b1; fin_dec = 1'b1;
					state_d = S_IDLE;
				end else if (area_q == 32'd0) begin
					state_d = S_TAB_RD;
				end else begin
					state_d = S_CLR;
				end
			end
			S_CLR: begin
				pix_we = 1'b1;
				if (clr_last)
					state_d = S_TAB_RD;
			end
			S_TAB_RD: begin
				ent_raddr = {col_q[13:0], 2'b00} + 16'd8 + ENTRY_AW'(cnt_q);
				state_d   = S_TAB_WT;
			end
			S_TAB_WT: state_d = (cnt_q == 2'd3) ? S_POST : S_TAB_RD;
			S_POST: begin
				ent_raddr = pos_q[15:0];
				if (pos_q >= {15'd0, size_q})
					col_end = 1'b1;
				else
					state_d = S_TOP_WT;
			end
			S_TOP_WT: begin
				ent_raddr = pos_q[15:0] + 16'd1;
				if (ent_rdata_q == END_MARK || (pos_q + 32'd1) == {15'd0, size_q})
					col_end = 1'b1;
				else
					state_d = S_LEN_WT;
			end
			S_LEN_WT: begin
				if (start_d + 18'(ent_rdata_q) > {1'b0, size_q})
					col_end = 1'b1;
				else if (ent_rdata_q == 8'd0)
					state_d = S_POST;
				else
					state_d = S_PIX_RD;
			end
			S_PIX_RD: begin
				ent_raddr = start_q[15:0] + 16'(y_q);
				state_d   = S_PIX_WT;
			end
			S_PIX_WT: state_d = S_PAL_RD;
			S_PAL_RD: state_d = S_PAL_WT;
			S_PAL_WT: state_d = (cnt_q == 2'd2) ? S_PIX_WR : S_PAL_RD;
			S_PIX_WR: begin
				pix_we    = ({7'd0, row_q} < h_q);
				pix_waddr = rowbase_q + col_q;
				pix_wdata = {1'b1, rgb_q};
				state_d   = (y_q == len_q - 8'd1) ? S_POST : S_PIX_RD;
			end
			default: state_d = S_IDLE;
		endcase
		// end of a column: next column or decode done
		if (col_end) begin
			if (col_last) begin
				fin = 1'b1; fin_dec = 1'b1;
				state_d = S_IDLE;
			end else begin
				state_d = S_TAB_RD;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// result register and decoded size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			dec_w_q    <= '0;
			dec_h_q    <= '0;
			dec_area_q <= '0;
		end else begin
			if (fin)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (fin_dec) begin
				dec_w_q    <= (fin_status == STAT_OK) ? w_q : 16'd0;
				dec_h_q    <= (fin_status == STAT_OK) ? h_q : 16'd0;
				dec_area_q <= (fin_status == STAT_OK) ? area_q[SIZE_W-1:0] : '0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fin) begin
			m_tdata_q[71:66] <= '0;
			m_tdata_q[1:0]   <= fin_status;
			m_tdata_q[65:34] <= fin_argb;
			if (fin_dec) begin
				m_tdata_q[17:2]  <= (fin_status == STAT_OK) ? w_q : 16'd0;
				m_tdata_q[33:18] <= (fin_status == STAT_OK) ? h_q : 16'd0;
			end else begin
				m_tdata_q[17:2]  <= dec_w_q;
				m_tdata_q[33:18] <= dec_h_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// decode walk datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			size_q <= size_sat;
			pnum_q <= pixel_number;
			cnt_q  <= '0;
		end
		unique case (state_q)
			S_HDR_WT: begin
				acc_q <= {ent_rdata_q, acc_q[31:8]};
				cnt_q <= cnt_q + 2'd1;
			end
			S_HDR_MUL: begin
				w_q    <= acc_q[15:0];
				h_q    <= acc_q[31:16];
				area_q <= 32'(acc_q[15:0]) * 32'(acc_q[31:16]);
			end
			S_HDR_CHK: begin
				clr_q <= '0;
				col_q <= '0;
				cnt_q <= '0;
			end
			S_CLR: clr_q <= clr_q + PIXEL_AW'(1);
			S_TAB_WT: begin
				acc_q <= {ent_rdata_q, acc_q[31:8]};
				pos_q <= {ent_rdata_q, acc_q[31:8]};
				cnt_q <= cnt_q + 2'd1;
			end
			S_TOP_WT: top_q <= ent_rdata_q;
			S_LEN_WT: begin
				len_q   <= ent_rdata_q;
				start_q <= start_d;
				y_q     <= '0;
				if (ent_rdata_q == 8'd0)
					pos_q <= 32'(start_d) + 32'd1;
			end
			S_PIX_RD: row_q <= 9'(top_q) + 9'(y_q);
			S_PIX_WT: begin
				pal_base_q <= {1'b0, ent_rdata_q, 1'b0} + PAL_AW'(ent_rdata_q);
				rowbase_q  <= PIXEL_AW'(row_q * w_q);
				cnt_q      <= '0;
			end
			S_PAL_WT: begin
				rgb_q <= {rgb_q[15:0], pal_rdata_q};
				cnt_q <= cnt_q + 2'd1;
			end
			S_PIX_WR: begin
				y_q <= y_q + 8'd1;
				if (y_q == len_q - 8'd1)
					pos_q <= 32'(start_q) + 32'(len_q) + 32'd1;
			end
			default: ;
		endcase
		if (col_end) begin
			col_q <= col_q + 16'd1;
			cnt_q <= '0;
		end
	end

	// palette store
	always_ff @(posedge clk) begin
		if (pal_we)
			pal_mem[palette_position] <= byte_value;
		pal_rdata_q <= pal_mem[pal_raddr];
	end

	// entry store
	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[entry_offset] <= byte_value;
		ent_rdata_q <= ent_mem[ent_raddr];
	end

	// pixel store
	always_ff @(posedge clk) begin
		if (pix_we)
			pix_mem[pix_waddr] <= pix_wdata;
		pix_rdata_q <= pix_mem[pixel_number];
	end

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE)
		else $error("ready outside idle");

	a_clr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> ({16'd0, clr_q} < area_q))
		else $error("clear pass beyond picture");

	a_area_cap: assert property (@(posedge clk) disable iff (!arst_n)
		dec_area_q <= SIZE_W'(PIXEL_DEPTH))
		else $error("decoded area beyond pixel store");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!m_tvalid_q || m_tready))
		else $error("result overwrites pending item");

endmodule
`default_nettype wire
